// File: src/lsc_pkg.sv
package lsc_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int KEY_W     = 31;

    // operation codes carried in the kind field
    localparam logic [1:0] KIND_GET = 2'd0;
    localparam logic [1:0] KIND_SET = 2'd1;
    localparam logic [1:0] KIND_DEL = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LRD,
        ST_LUN,
        ST_APP,
        ST_APP2,
        ST_DRD,
        ST_DMV,
        ST_DFIX,
        ST_DONE
    } t_state;

endpackage

// File: src/lsc_req_if.sv
interface lsc_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic [lsc_pkg::KEY_W-1:0]  key;
    logic                       dirty_in;

    modport source (output valid, kind, key, dirty_in, input ready);
    modport sink   (input valid, kind, key, dirty_in, output ready);
endinterface

// File: src/lsc_res_if.sv
interface lsc_res_if #(
    parameter int SW = $clog2(lsc_pkg::SLOTS_DEF),
    parameter int OW = $clog2(lsc_pkg::SLOTS_DEF + 1)
);
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [SW-1:0]              slot;
    logic                       load_needed;
    logic                       evicted;
    logic [lsc_pkg::KEY_W-1:0]  victim_key;
    logic                       write_back;
    logic                       moved;
    logic [SW-1:0]              moved_from;
    logic                       removed;
    logic [OW-1:0]              occupancy;

    modport source (output valid, hit, slot, load_needed, evicted, victim_key, write_back,
                    moved, moved_from, removed, occupancy, input ready);
    modport sink   (input valid, hit, slot, load_needed, evicted, victim_key, write_back,
                    moved, moved_from, removed, occupancy, output ready);
endinterface

// File: src/lsc_key_mem.sv
module lsc_key_mem #(
    parameter int DEPTH = lsc_pkg::SLOTS_DEF,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    // dirty mark in the top bit, key below
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/lsc_link_mem.sv
module lsc_link_mem #(
    parameter int SLOTS = lsc_pkg::SLOTS_DEF,
    parameter int SW    = 6,
    parameter int LW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [SW-1:0] i_raddr,
    input  logic          i_nx_we,
    input  logic [LW-1:0] i_nx_node,
    input  logic [LW-1:0] i_nx_val,
    input  logic          i_pv_we,
    input  logic [LW-1:0] i_pv_node,
    input  logic [LW-1:0] i_pv_val,
    output logic [LW-1:0] o_next,
    output logic [LW-1:0] o_prev,
    output logic [LW-1:0] o_head_next,
    output logic [LW-1:0] o_tail_prev
);

    localparam logic [LW-1:0] HEAD = LW'(SLOTS);
    localparam logic [LW-1:0] TAIL = LW'(SLOTS + 1);

    logic [LW-1:0] next_mem [SLOTS];
    logic [LW-1:0] prev_mem [SLOTS];
    logic [LW-1:0] r_next;
    logic [LW-1:0] r_prev;
    logic [LW-1:0] r_head_next;
    logic [LW-1:0] r_tail_prev;

    // sentinel links live in flops, slot links in memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_next <= TAIL;
            r_tail_prev <= HEAD;
        end else begin
            if (i_nx_we && i_nx_node == HEAD) begin
                r_head_next <= i_nx_val;
            end
            if (i_pv_we && i_pv_node == TAIL) begin
                r_tail_prev <= i_pv_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_nx_we && i_nx_node < HEAD) begin
            next_mem[i_nx_node[SW-1:0]] <= i_nx_val;
        end
        if (i_pv_we && i_pv_node < HEAD) begin
            prev_mem[i_pv_node[SW-1:0]] <= i_pv_val;
        end
        r_next <= next_mem[i_raddr];
        r_prev <= prev_mem[i_raddr];
    end

    assign o_next      = r_next;
    assign o_prev      = r_prev;
    assign o_head_next = r_head_next;
    assign o_tail_prev = r_tail_prev;

    a_head_not_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_next != HEAD)
        else $error("head sentinel links to itself");

    a_tail_not_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_prev != TAIL)
        else $error("tail sentinel links to itself");

    a_no_tail_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_nx_we |-> (i_nx_node != TAIL && i_nx_val != HEAD))
        else $error("forward link write out of order");

endmodule

// File: src/lru_slot_cache_controller_unit.sv
// flow: key scan over the filled slots after the accept, then the link update states and the
//   result register; done waits for the result register to be free
// throughput: one transaction at a time, accepted only in idle; the key scan over
//   the single key memory read port, one slot per cycle, sets the rate
// reset: synchronous active low; clears occupancy, control and result valid, sets capacity
//   to the slot count and the lru list to empty; no memory clearing pass
module lru_slot_cache_controller_unit #(
    parameter int SLOTS = lsc_pkg::SLOTS_DEF,
    localparam int SW   = $clog2(SLOTS),
    localparam int LW   = $clog2(SLOTS + 2),
    localparam int CW   = $clog2(SLOTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsc_req_if.sink       i_req,
    lsc_res_if.source     o_res,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_data
);

    localparam int KW = lsc_pkg::KEY_W;
    localparam logic [LW-1:0] TAIL = LW'(SLOTS + 1);

    lsc_pkg::t_state r_state, n_state;

    // configuration and occupancy
    logic [CW-1:0] r_cap;
    logic [CW-1:0] r_filled;
    logic [CW-1:0] eff_cap;

    // transaction being worked on
    logic [1:0]    r_kind;
    logic [KW-1:0] r_key;
    logic          r_dirty;

    // scan state
    logic [CW-1:0] r_idx;
    logic [SW-1:0] r_cmp;
    logic          r_pend;
    logic          match;

    // working result
    logic [SW-1:0] r_pos;
    logic          r_found;
    logic          r_evict;
    logic [KW-1:0] r_vkey;
    logic          r_wb;
    logic          r_moved;
    logic [LW-1:0] r_p;
    logic [LW-1:0] r_n;

    // result register
    logic          r_ovalid;
    logic          r_ohit;
    logic [SW-1:0] r_oslot;
    logic          r_oload;
    logic          r_oevict;
    logic [KW-1:0] r_ovkey;
    logic          r_owb;
    logic          r_omoved;
    logic [SW-1:0] r_ofrom;
    logic          r_oremoved;
    logic [CW-1:0] r_oocc;

    // memory ports
    logic          k_we;
    logic [SW-1:0] k_waddr;
    logic [KW:0]   k_wdata;
    logic [SW-1:0] k_raddr;
    logic [KW:0]   k_rdata;
    logic [SW-1:0] l_raddr;
    logic          nx_we;
    logic [LW-1:0] nx_node;
    logic [LW-1:0] nx_val;
    logic          pv_we;
    logic [LW-1:0] pv_node;
    logic [LW-1:0] pv_val;
    logic [LW-1:0] l_next;
    logic [LW-1:0] l_prev;
    logic [LW-1:0] head_next;
    logic [LW-1:0] tail_prev;

    logic          in_acc;
    logic          out_free;
    logic          valid_kind;

    lsc_key_mem #(
        .DEPTH (SLOTS),
        .AW    (SW),
        .DW    (KW + 1)
    ) u_key_mem (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (k_wdata),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    lsc_link_mem #(
        .SLOTS (SLOTS),
        .SW    (SW),
        .LW    (LW)
    ) u_link_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_raddr     (l_raddr),
        .i_nx_we     (nx_we),
        .i_nx_node   (nx_node),
        .i_nx_val    (nx_val),
        .i_pv_we     (pv_we),
        .i_pv_node   (pv_node),
        .i_pv_val    (pv_val),
        .o_next      (l_next),
        .o_prev      (l_prev),
        .o_head_next (head_next),
        .o_tail_prev (tail_prev)
    );

    // capacity of zero acts as one, anything above the slot count as the slot count
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CW'(1);
        end else if (r_cap > CW'(SLOTS)) begin
            eff_cap = CW'(SLOTS);
        end else begin
            eff_cap = r_cap;
        end
    end

    assign in_acc     = i_req.valid && i_req.ready;
    assign out_free   = !r_ovalid || o_res.ready;
    assign valid_kind = (r_kind == lsc_pkg::KIND_GET) || (r_kind == lsc_pkg::KIND_SET)
                        || (r_kind == lsc_pkg::KIND_DEL);
    // key read data belongs to slot r_cmp when a read is pending
    assign match      = r_pend && (k_rdata[KW-1:0] == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsc_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_req.kind == lsc_pkg::KIND_GET || i_req.kind == lsc_pkg::KIND_SET
                        || i_req.kind == lsc_pkg::KIND_DEL) begin
                        n_state = lsc_pkg::ST_SCAN;
                    end else begin
                        n_state = lsc_pkg::ST_DONE;
                    end
                end
            end
            lsc_pkg::ST_SCAN: begin
                if (match) begin
                    n_state = lsc_pkg::ST_LRD;
                end else if (r_idx < r_filled) begin
                    n_state = lsc_pkg::ST_SCAN;
                end else if (r_kind == lsc_pkg::KIND_DEL) begin
                    n_state = lsc_pkg::ST_DONE;
                end else if (r_filled >= eff_cap) begin
                    n_state = lsc_pkg::ST_LRD;
                end else begin
                    n_state = lsc_pkg::ST_APP;
                end
            end
            lsc_pkg::ST_LRD: n_state = lsc_pkg::ST_LUN;
            lsc_pkg::ST_LUN: begin
                if (r_kind != lsc_pkg::KIND_DEL) begin
                    n_state = lsc_pkg::ST_APP;
                end else if (CW'(r_pos) < r_filled - CW'(1)) begin
                    n_state = lsc_pkg::ST_DRD;
                end else begin
                    n_state = lsc_pkg::ST_DONE;
                end
            end
            lsc_pkg::ST_APP:  n_state = lsc_pkg::ST_APP2;
            lsc_pkg::ST_APP2: n_state = lsc_pkg::ST_DONE;
            lsc_pkg::ST_DRD:  n_state = lsc_pkg::ST_DMV;
            lsc_pkg::ST_DMV:  n_state = lsc_pkg::ST_DFIX;
            lsc_pkg::ST_DFIX: n_state = lsc_pkg::ST_DONE;
            lsc_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = lsc_pkg::ST_IDLE;
                end
            end
            default: n_state = lsc_pkg::ST_IDLE;
        endcase
    end

    // memory and handshake control
    always_comb begin
        i_req.ready = 1'b0;
        k_we        = 1'b0;
        k_waddr     = r_pos;
        k_wdata     = {(r_kind == lsc_pkg::KIND_SET) ? r_dirty : 1'b0, r_key};
        k_raddr     = r_pos;
        l_raddr     = r_pos;
        nx_we       = 1'b0;
        nx_node     = l_prev;
        nx_val      = l_next;
        pv_we       = 1'b0;
        pv_node     = l_next;
        pv_val      = l_prev;
        unique case (r_state)
            lsc_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            lsc_pkg::ST_SCAN: begin
                k_raddr = r_idx[SW-1:0];
            end
            lsc_pkg::ST_LRD: begin
                // neighbors and old key of the slot
            end
            lsc_pkg::ST_LUN: begin
                // unlink: next[prev] = next, prev[next] = prev
                nx_we = 1'b1;
                pv_we = 1'b1;
                // set overwrites the dirty mark, an evicting miss loads the new key
                k_we  = (r_kind == lsc_pkg::KIND_SET) || r_evict;
            end
            lsc_pkg::ST_APP: begin
                // link after the current most recent entry
                nx_we   = 1'b1;
                nx_node = tail_prev;
                nx_val  = LW'(r_pos);
                pv_we   = 1'b1;
                pv_node = TAIL;
                pv_val  = LW'(r_pos);
                // fill of a fresh slot
                k_we    = !r_found && !r_evict;
            end
            lsc_pkg::ST_APP2: begin
                nx_we   = 1'b1;
                nx_node = LW'(r_pos);
                nx_val  = TAIL;
                pv_we   = 1'b1;
                pv_node = LW'(r_pos);
                pv_val  = r_p;
            end
            lsc_pkg::ST_DRD: begin
                // last filled slot, its index already equal to the new occupancy
                k_raddr = r_filled[SW-1:0];
                l_raddr = r_filled[SW-1:0];
            end
            lsc_pkg::ST_DMV: begin
                // moved entry takes the freed slot, neighbors point at it
                k_we    = 1'b1;
                k_wdata = k_rdata;
                nx_we   = 1'b1;
                nx_val  = LW'(r_pos);
                pv_we   = 1'b1;
                pv_val  = LW'(r_pos);
            end
            lsc_pkg::ST_DFIX: begin
                nx_we   = 1'b1;
                nx_node = LW'(r_pos);
                nx_val  = r_n;
                pv_we   = 1'b1;
                pv_node = LW'(r_pos);
                pv_val  = r_p;
            end
            lsc_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lsc_pkg::ST_IDLE;
            r_cap    <= CW'(SLOTS);
            r_filled <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            // a new result may replace the one leaving in the same cycle
            if (r_state == lsc_pkg::ST_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                lsc_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        r_kind  <= i_req.kind;
                        r_key   <= i_req.key;
                        r_dirty <= i_req.dirty_in;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_pos   <= '0;
                        r_found <= 1'b0;
                        r_evict <= 1'b0;
                        r_vkey  <= '0;
                        r_wb    <= 1'b0;
                        r_moved <= 1'b0;
                    end
                end
                lsc_pkg::ST_SCAN: begin
                    if (match) begin
                        r_found <= 1'b1;
                        r_pos   <= r_cmp;
                        r_pend  <= 1'b0;
                    end else if (r_idx < r_filled) begin
                        r_cmp  <= r_idx[SW-1:0];
                        r_idx  <= r_idx + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (r_kind != lsc_pkg::KIND_DEL) begin
                            if (r_filled >= eff_cap) begin
                                // least recent entry gives up its slot
                                r_evict <= 1'b1;
                                r_pos   <= head_next[SW-1:0];
                            end else begin
                                r_pos    <= r_filled[SW-1:0];
                                r_filled <= r_filled + CW'(1);
                            end
                        end
                    end
                end
                lsc_pkg::ST_LUN: begin
                    if (r_evict) begin
                        r_vkey <= k_rdata[KW-1:0];
                        r_wb   <= k_rdata[KW];
                    end
                    if (r_kind == lsc_pkg::KIND_DEL) begin
                        r_filled <= r_filled - CW'(1);
                    end
                end
                lsc_pkg::ST_APP: begin
                    r_p <= tail_prev;
                end
                lsc_pkg::ST_DMV: begin
                    r_p     <= l_prev;
                    r_n     <= l_next;
                    r_moved <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == lsc_pkg::ST_DONE && out_free) begin
            r_ohit     <= r_found && valid_kind;
            r_oslot    <= r_pos;
            r_oload    <= (r_kind == lsc_pkg::KIND_GET) && !r_found;
            r_oevict   <= r_evict;
            r_ovkey    <= r_vkey;
            r_owb      <= r_wb;
            r_omoved   <= r_moved;
            r_ofrom    <= r_moved ? r_filled[SW-1:0] : '0;
            r_oremoved <= (r_kind == lsc_pkg::KIND_DEL) && r_found;
            r_oocc     <= r_filled;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.hit         = r_ohit;
    assign o_res.slot        = r_oslot;
    assign o_res.load_needed = r_oload;
    assign o_res.evicted     = r_oevict;
    assign o_res.victim_key  = r_ovkey;
    assign o_res.write_back  = r_owb;
    assign o_res.moved       = r_omoved;
    assign o_res.moved_from  = r_ofrom;
    assign o_res.removed     = r_oremoved;
    assign o_res.occupancy   = r_oocc;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CW'(SLOTS))
        else $error("occupancy beyond slot count");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.evicted && o_res.hit))
        else $error("eviction reported on a hit");

    a_moved_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.moved |-> o_res.removed)
        else $error("move without delete");

    a_del_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lsc_pkg::ST_LUN && r_kind == lsc_pkg::KIND_DEL
        |=> r_filled == $past(r_filled) - CW'(1))
        else $error("delete did not free a slot");

endmodule
